>>> src/gpma_pkg.sv
// Shared types and constants for the GF(2) polynomial modular ALU.
package gpma_pkg;

    localparam int WORD_W      = 32;
    localparam int RES_W       = 31;
    localparam int POLY_BITS_D = 32;
    localparam int QUEUE_DEPTH = 2;
    localparam logic [WORD_W-1:0] MODULUS_RESET = 32'd285;

    typedef enum logic [2:0] {
        CMD_ADD = 3'd0,
        CMD_MUL = 3'd1,
        CMD_DIV = 3'd2,
        CMD_REC = 3'd3,
        CMD_POW = 3'd4
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_NOINV  = 2'd1,
        ST_ZPOW   = 2'd2,
        ST_MINEXP = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DEGM,
        S_RED_A,
        S_RED_B,
        S_DISP,
        S_MUL,
        S_INV_DEG,
        S_INV_CHK,
        S_INV_SH,
        S_INV_RET,
        S_PW_CHK,
        S_DONE
    } state_t;

    typedef enum logic [1:0] {
        RET_OUT,
        RET_PW_ACC,
        RET_PW_SQ
    } ret_t;

    typedef struct packed {
        cmd_t              cmd;
        logic [WORD_W-1:0] opa;
        logic [WORD_W-1:0] opb;
        logic [WORD_W-1:0] mag;
        logic              e_zero;
        logic              e_neg;
        logic              e_min;
    } item_t;

endpackage

>>> src/gpma_front.sv
// Front end: accepts a beat and classifies the command and exponent.
module gpma_front (
    input  logic [2:0]                     command,
    input  logic [gpma_pkg::WORD_W-1:0]    operand_a,
    input  logic [gpma_pkg::WORD_W-1:0]    operand_b,
    input  logic signed [gpma_pkg::WORD_W-1:0] exponent,
    output gpma_pkg::item_t                item
);

    logic [gpma_pkg::WORD_W-1:0] e_u;

    always_comb
    begin
        e_u         = gpma_pkg::WORD_W'(exponent);
        item.cmd    = gpma_pkg::cmd_t'(command);
        item.opa    = operand_a;
        item.opb    = operand_b;
        item.e_zero = (e_u == '0);
        item.e_neg  = e_u[gpma_pkg::WORD_W-1];
        item.e_min  = e_u[gpma_pkg::WORD_W-1] && (e_u[gpma_pkg::WORD_W-2:0] == '0);
        item.mag    = e_u[gpma_pkg::WORD_W-1] ? (~e_u + 1'b1) : e_u;
    end

endmodule

>>> src/gpma_queue.sv
// Short queue of classified items between front and back.
module gpma_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            wr_en,
    input  gpma_pkg::item_t wr_item,
    output logic            full,
    input  logic            rd_en,
    output logic            rd_valid,
    output gpma_pkg::item_t rd_item
);

    localparam int PW = (gpma_pkg::QUEUE_DEPTH > 1) ? $clog2(gpma_pkg::QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(gpma_pkg::QUEUE_DEPTH + 1);

    gpma_pkg::item_t mem [gpma_pkg::QUEUE_DEPTH];
    logic [PW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0] count_reg;
    logic          do_wr, do_rd;

    assign full     = (count_reg == CW'(gpma_pkg::QUEUE_DEPTH));
    assign rd_valid = (count_reg != '0);
    assign do_wr    = wr_en && !full;
    assign do_rd    = rd_en && rd_valid;
    assign rd_item  = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem[wr_ptr_reg] <= wr_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(gpma_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                             : wr_ptr_reg + 1'b1;
            end
            if (do_rd)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(gpma_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                             : rd_ptr_reg + 1'b1;
            end
            if (do_wr && !do_rd)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_rd && !do_wr)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

>>> src/gpma_back.sv
// Back end: bit-serial reduce, multiply, inverse and power sequencer with result register.
module gpma_back #(
    parameter int POLY_BITS = gpma_pkg::POLY_BITS_D
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [gpma_pkg::WORD_W-1:0]  modulus,
    input  logic                         q_valid,
    input  gpma_pkg::item_t              q_item,
    output logic                         q_pop,
    output logic                         empty,
    input  logic                         pop,
    output logic [gpma_pkg::RES_W-1:0]   result_poly,
    output logic [1:0]                   status
);

    localparam int EW = (POLY_BITS < gpma_pkg::WORD_W) ? POLY_BITS : gpma_pkg::WORD_W;
    localparam int DW = $clog2(EW);

    function automatic logic [EW-1:0] xt(input logic [EW-1:0] r, input logic [EW-1:0] m,
                                         input logic [DW-1:0] d);
        logic [EW-1:0] s;
        begin
            s = {r[EW-2:0], 1'b0};
            if (s[d])
            begin
                s = s ^ m;
            end
            return s;
        end
    endfunction

    gpma_pkg::state_t  state_reg, state_next;
    gpma_pkg::ret_t    ret_reg, ret_next;
    gpma_pkg::cmd_t    cmd_reg, cmd_next;
    gpma_pkg::status_t st_reg, st_next;
    logic [gpma_pkg::WORD_W-1:0] mag_reg, mag_next;
    logic e_zero_reg, e_zero_next, e_neg_reg, e_neg_next, e_min_reg, e_min_next;
    logic [EW-1:0] a_reg, a_next, b_reg, b_next, r_reg, r_next;
    logic [EW-1:0] mx_reg, mx_next, my_reg, my_next, acc_reg, acc_next, base_reg, base_next;
    logic [EW-1:0] u_reg, u_next, v_reg, v_next, g1_reg, g1_next, g2_reg, g2_next;
    logic [EW-1:0] t_reg, t_next, tg_reg, tg_next, res_reg, res_next;
    logic [DW-1:0] du_reg, du_next, dv_reg, dv_next, dm_reg, dm_next, cnt_reg, cnt_next;
    logic          out_valid_reg, out_valid_next;
    logic [gpma_pkg::RES_W-1:0] out_res_reg, out_res_next;
    gpma_pkg::status_t out_st_reg, out_st_next;

    logic [EW-1:0] m, xr, red_val, mul_val, one;
    logic          red_bit;
    logic [gpma_pkg::WORD_W-1:0] res_w;

    assign m           = modulus[EW-1:0];
    assign one         = EW'(1);
    assign empty       = !out_valid_reg;
    assign result_poly = out_res_reg;
    assign status      = out_st_reg;

    always_comb
    begin
        xr      = xt(r_reg, m, dm_reg);
        red_bit = (state_reg == gpma_pkg::S_RED_A) ? a_reg[cnt_reg] : b_reg[cnt_reg];
        red_val = xr ^ {{(EW-1){1'b0}}, red_bit};
        mul_val = xr ^ (my_reg[cnt_reg] ? mx_reg : '0);
        res_w   = gpma_pkg::WORD_W'(res_reg);
    end

    always_comb
    begin
        state_next     = state_reg;
        ret_next       = ret_reg;
        cmd_next       = cmd_reg;
        st_next        = st_reg;
        mag_next       = mag_reg;
        e_zero_next    = e_zero_reg;
        e_neg_next     = e_neg_reg;
        e_min_next     = e_min_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        r_next         = r_reg;
        mx_next        = mx_reg;
        my_next        = my_reg;
        acc_next       = acc_reg;
        base_next      = base_reg;
        u_next         = u_reg;
        v_next         = v_reg;
        g1_next        = g1_reg;
        g2_next        = g2_reg;
        t_next         = t_reg;
        tg_next        = tg_reg;
        res_next       = res_reg;
        du_next        = du_reg;
        dv_next        = dv_reg;
        dm_next        = dm_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && !pop;
        out_res_next   = out_res_reg;
        out_st_next    = out_st_reg;
        q_pop          = 1'b0;

        unique case (state_reg)
            gpma_pkg::S_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop       = 1'b1;
                    cmd_next    = q_item.cmd;
                    a_next      = q_item.opa[EW-1:0];
                    b_next      = q_item.opb[EW-1:0];
                    mag_next    = q_item.mag;
                    e_zero_next = q_item.e_zero;
                    e_neg_next  = q_item.e_neg;
                    e_min_next  = q_item.e_min;
                    st_next     = gpma_pkg::ST_OK;
                    res_next    = '0;
                    dm_next     = DW'(EW - 1);
                    state_next  = gpma_pkg::S_DEGM;
                end
            end
            gpma_pkg::S_DEGM:
            begin
                if (m[dm_reg] || (dm_reg == '0))
                begin
                    r_next     = '0;
                    cnt_next   = DW'(EW - 1);
                    state_next = (dm_reg == '0) ? gpma_pkg::S_DONE : gpma_pkg::S_RED_A;
                end
                else
                begin
                    dm_next = dm_reg - 1'b1;
                end
            end
            gpma_pkg::S_RED_A, gpma_pkg::S_RED_B:
            begin
                r_next   = red_val;
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    r_next   = '0;
                    cnt_next = DW'(EW - 1);
                    if (state_reg == gpma_pkg::S_RED_A)
                    begin
                        a_next     = red_val;
                        state_next = gpma_pkg::S_RED_B;
                    end
                    else
                    begin
                        b_next     = red_val;
                        state_next = gpma_pkg::S_DISP;
                    end
                end
            end
            gpma_pkg::S_DISP:
            begin
                state_next = gpma_pkg::S_DONE;
                u_next     = a_reg;
                g1_next    = one;
                v_next     = m;
                g2_next    = '0;
                du_next    = dm_reg - 1'b1;
                dv_next    = dm_reg;
                case (cmd_reg)
                    gpma_pkg::CMD_ADD:
                    begin
                        res_next = a_reg ^ b_reg;
                    end
                    gpma_pkg::CMD_MUL:
                    begin
                        mx_next    = a_reg;
                        my_next    = b_reg;
                        ret_next   = gpma_pkg::RET_OUT;
                        state_next = gpma_pkg::S_MUL;
                    end
                    gpma_pkg::CMD_DIV:
                    begin
                        u_next     = b_reg;
                        state_next = gpma_pkg::S_INV_DEG;
                    end
                    gpma_pkg::CMD_REC:
                    begin
                        state_next = gpma_pkg::S_INV_DEG;
                    end
                    gpma_pkg::CMD_POW:
                    begin
                        if (e_zero_reg)
                        begin
                            if (a_reg == '0)
                            begin
                                st_next = gpma_pkg::ST_ZPOW;
                            end
                            else
                            begin
                                res_next = one;
                            end
                        end
                        else if (e_neg_reg)
                        begin
                            if (a_reg == '0)
                            begin
                                st_next = gpma_pkg::ST_NOINV;
                            end
                            else if (e_min_reg)
                            begin
                                st_next = gpma_pkg::ST_MINEXP;
                            end
                            else
                            begin
                                state_next = gpma_pkg::S_INV_DEG;
                            end
                        end
                        else
                        begin
                            base_next  = a_reg;
                            acc_next   = one;
                            state_next = gpma_pkg::S_PW_CHK;
                        end
                    end
                    default:
                    begin
                        res_next = '0;
                    end
                endcase
            end
            gpma_pkg::S_MUL:
            begin
                r_next   = mul_val;
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    r_next   = '0;
                    cnt_next = DW'(EW - 1);
                    case (ret_reg)
                        gpma_pkg::RET_OUT:
                        begin
                            res_next   = mul_val;
                            state_next = gpma_pkg::S_DONE;
                        end
                        gpma_pkg::RET_PW_ACC:
                        begin
                            acc_next = mul_val;
                            mx_next  = base_reg;
                            my_next  = base_reg;
                            ret_next = gpma_pkg::RET_PW_SQ;
                        end
                        default:
                        begin
                            base_next  = mul_val;
                            mag_next   = mag_reg >> 1;
                            state_next = gpma_pkg::S_PW_CHK;
                        end
                    endcase
                end
            end
            gpma_pkg::S_INV_DEG:
            begin
                if (u_reg[du_reg] || (du_reg == '0))
                begin
                    state_next = gpma_pkg::S_INV_CHK;
                end
                else
                begin
                    du_next = du_reg - 1'b1;
                end
            end
            gpma_pkg::S_INV_CHK:
            begin
                state_next = gpma_pkg::S_INV_SH;
                if (u_reg == '0)
                begin
                    if (v_reg == one)
                    begin
                        base_next  = g2_reg;
                        state_next = gpma_pkg::S_INV_RET;
                    end
                    else
                    begin
                        st_next    = gpma_pkg::ST_NOINV;
                        state_next = gpma_pkg::S_DONE;
                    end
                end
                else if (du_reg < dv_reg)
                begin
                    u_next   = v_reg;
                    v_next   = u_reg;
                    g1_next  = g2_reg;
                    g2_next  = g1_reg;
                    du_next  = dv_reg;
                    dv_next  = du_reg;
                    t_next   = u_reg;
                    tg_next  = g1_reg;
                    cnt_next = dv_reg - du_reg;
                end
                else
                begin
                    t_next   = v_reg;
                    tg_next  = g2_reg;
                    cnt_next = du_reg - dv_reg;
                end
            end
            gpma_pkg::S_INV_SH:
            begin
                if (cnt_reg == '0)
                begin
                    u_next     = u_reg ^ t_reg;
                    g1_next    = g1_reg ^ tg_reg;
                    state_next = gpma_pkg::S_INV_DEG;
                end
                else
                begin
                    t_next   = {t_reg[EW-2:0], 1'b0};
                    tg_next  = xt(tg_reg, m, dm_reg);
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            gpma_pkg::S_INV_RET:
            begin
                r_next     = '0;
                cnt_next   = DW'(EW - 1);
                state_next = gpma_pkg::S_DONE;
                case (cmd_reg)
                    gpma_pkg::CMD_REC:
                    begin
                        res_next = base_reg;
                    end
                    gpma_pkg::CMD_DIV:
                    begin
                        mx_next    = a_reg;
                        my_next    = base_reg;
                        ret_next   = gpma_pkg::RET_OUT;
                        state_next = gpma_pkg::S_MUL;
                    end
                    default:
                    begin
                        acc_next   = one;
                        state_next = gpma_pkg::S_PW_CHK;
                    end
                endcase
            end
            gpma_pkg::S_PW_CHK:
            begin
                r_next   = '0;
                cnt_next = DW'(EW - 1);
                if (mag_reg == '0)
                begin
                    res_next   = acc_reg;
                    state_next = gpma_pkg::S_DONE;
                end
                else if (mag_reg[0])
                begin
                    mx_next    = acc_reg;
                    my_next    = base_reg;
                    ret_next   = gpma_pkg::RET_PW_ACC;
                    state_next = gpma_pkg::S_MUL;
                end
                else
                begin
                    mx_next    = base_reg;
                    my_next    = base_reg;
                    ret_next   = gpma_pkg::RET_PW_SQ;
                    state_next = gpma_pkg::S_MUL;
                end
            end
            gpma_pkg::S_DONE:
            begin
                if (!out_valid_reg)
                begin
                    out_valid_next = 1'b1;
                    out_res_next   = (st_reg == gpma_pkg::ST_OK) ? res_w[gpma_pkg::RES_W-1:0]
                                                                 : '0;
                    out_st_next    = st_reg;
                    state_next     = gpma_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = gpma_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= gpma_pkg::S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ret_reg     <= ret_next;
        cmd_reg     <= cmd_next;
        st_reg      <= st_next;
        mag_reg     <= mag_next;
        e_zero_reg  <= e_zero_next;
        e_neg_reg   <= e_neg_next;
        e_min_reg   <= e_min_next;
        a_reg       <= a_next;
        b_reg       <= b_next;
        r_reg       <= r_next;
        mx_reg      <= mx_next;
        my_reg      <= my_next;
        acc_reg     <= acc_next;
        base_reg    <= base_next;
        u_reg       <= u_next;
        v_reg       <= v_next;
        g1_reg      <= g1_next;
        g2_reg      <= g2_next;
        t_reg       <= t_next;
        tg_reg      <= tg_next;
        res_reg     <= res_next;
        du_reg      <= du_next;
        dv_reg      <= dv_next;
        dm_reg      <= dm_next;
        cnt_reg     <= cnt_next;
        out_res_reg <= out_res_next;
        out_st_reg  <= out_st_next;
    end

endmodule

>>> src/gf2_poly_mod_alu_core.sv
// Top level of the GF(2) polynomial modular ALU.
// Input channel: a beat (command, operands, exponent) is taken when push is high and
// full is low. Result channel: result_poly and status are valid while empty is low and
// are taken when pop is high. The modulus is written through cfg_we / cfg_wdata; the user
// must write it only while the block is idle, as the block does not enforce this. It resets
// to x^8+x^4+x^3+x^2+1. Items are processed one at a time by a bit-serial back end of
// width W = min(POLY_BITS, 32) that does one shift and conditional XOR per cycle. Every
// item first finds the modulus degree and, if that degree is above zero, reduces both
// operands. Add is then a single XOR, multiply a shift-and-XOR loop, reciprocal an
// extended Euclid (one shift or degree step a cycle), divide a reciprocal followed by a
// multiply, and power a square-and-multiply loop over the exponent bits plus an inverse
// for negative exponents; a negative power is the worst case, loop and inverse together.
// A two-entry queue sits between front and back, so new beats are taken while a result
// waits. When the receiver stalls, the finished result holds in the output register and
// the back end waits before writing the next one. Reset empties the queue and the output.
module gf2_poly_mod_alu_core #(
    parameter int POLY_BITS = gpma_pkg::POLY_BITS_D
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               push,
    output logic                               full,
    input  logic [2:0]                         command,
    input  logic [gpma_pkg::WORD_W-1:0]        operand_a,
    input  logic [gpma_pkg::WORD_W-1:0]        operand_b,
    input  logic signed [gpma_pkg::WORD_W-1:0] exponent,
    output logic                               empty,
    input  logic                               pop,
    output logic [gpma_pkg::RES_W-1:0]         result_poly,
    output logic [1:0]                         status,
    input  logic                               cfg_we,
    input  logic [gpma_pkg::WORD_W-1:0]        cfg_wdata
);

    logic [gpma_pkg::WORD_W-1:0] modulus_reg;
    gpma_pkg::item_t front_item, q_item;
    logic q_valid, q_pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modulus_reg <= gpma_pkg::MODULUS_RESET;
        end
        else if (cfg_we)
        begin
            modulus_reg <= cfg_wdata;
        end
    end

    gpma_front u_front (
        .command   (command),
        .operand_a (operand_a),
        .operand_b (operand_b),
        .exponent  (exponent),
        .item      (front_item)
    );

    gpma_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (push),
        .wr_item  (front_item),
        .full     (full),
        .rd_en    (q_pop),
        .rd_valid (q_valid),
        .rd_item  (q_item)
    );

    gpma_back #(
        .POLY_BITS (POLY_BITS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .modulus     (modulus_reg),
        .q_valid     (q_valid),
        .q_item      (q_item),
        .q_pop       (q_pop),
        .empty       (empty),
        .pop         (pop),
        .result_poly (result_poly),
        .status      (status)
    );

endmodule

>>> verif/tb_top.sv
// Self-checking testbench for the GF(2) polynomial modular ALU core.
`timescale 1ns / 1ps

module tb_top;

    localparam int MAX_IDLE = 40000;

    typedef struct {
        logic [2:0]  cmd;
        logic [31:0] opa;
        logic [31:0] opb;
        logic [31:0] expo;
    } beat_t;

    typedef struct {
        logic [30:0] poly;
        logic [1:0]  st;
    } answer_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    logic [2:0]  command = '0;
    logic [31:0] operand_a = '0;
    logic [31:0] operand_b = '0;
    logic signed [31:0] exponent = '0;
    logic        empty;
    logic        pop = 1'b0;
    logic [30:0] result_poly;
    logic [1:0]  status;
    logic        cfg_we = 1'b0;
    logic [31:0] cfg_wdata = '0;

    beat_t   pending_q[$];
    answer_t answer_q[$];
    logic [31:0] modulus = gpma_pkg::MODULUS_RESET;
    int      send_idle_pct = 13;
    int      recv_idle_pct = 62;
    int      hold_cycles = 0;
    int      mismatches = 0;
    int      results_seen = 0;
    int      beats_sent = 0;
    int      idle_count = 0;
    logic    in_flight = 1'b0;

    gf2_poly_mod_alu_core dut (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full), .command(command),
        .operand_a(operand_a), .operand_b(operand_b), .exponent(exponent),
        .empty(empty), .pop(pop), .result_poly(result_poly), .status(status),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
    );

    always #10 clk = ~clk;

    function automatic int deg_of(logic [63:0] p);
        int d;
        d = -1;
        for (int i = 0; i < 64; i++)
            if (p[i])
                d = i;
        return d;
    endfunction

    function automatic logic [63:0] reduce_by(logic [63:0] x, logic [63:0] m);
        int dm;
        int dx;
        dm = deg_of(m);
        dx = deg_of(x);
        while (dx >= dm)
        begin
            x ^= m << (dx - dm);
            dx = deg_of(x);
        end
        return x;
    endfunction

    function automatic logic [63:0] clmul_mod(logic [63:0] a, logic [63:0] b,
                                              logic [63:0] m);
        logic [63:0] r;
        int dm;
        dm = deg_of(m);
        r = '0;
        for (int i = 63; i >= 0; i--)
        begin
            r <<= 1;
            if (r[dm])
                r ^= m;
            if (b[i])
                r ^= a;
        end
        return r;
    endfunction

    function automatic bit invert_mod(logic [63:0] a, logic [63:0] m,
                                      output logic [63:0] inv);
        logic [63:0] r0, r1, s0, s1, q, r, t;
        int d1;
        int dr;
        r0 = m; r1 = a; s0 = 0; s1 = 1; inv = 0;
        while (r1 != 0)
        begin
            q = 0;
            r = r0;
            d1 = deg_of(r1);
            dr = deg_of(r);
            while (dr >= d1)
            begin
                q[dr - d1] = 1'b1;
                r ^= r1 << (dr - d1);
                dr = deg_of(r);
            end
            r0 = r1;
            r1 = r;
            t = s0 ^ clmul_mod(reduce_by(q, m), s1, m);
            s0 = s1;
            s1 = t;
        end
        if (r0 != 1)
            return 1'b0;
        inv = reduce_by(s0, m);
        return 1'b1;
    endfunction

    function automatic answer_t predict_residue(beat_t b, logic [31:0] modv);
        answer_t ans;
        logic [63:0] m, a, bb, t, base, acc;
        logic [31:0] mag;
        bit ok;
        m = {32'd0, modv};
        ans.poly = '0;
        ans.st = gpma_pkg::ST_OK;
        if (deg_of(m) >= 1)
        begin
            a = reduce_by({32'd0, b.opa}, m);
            bb = reduce_by({32'd0, b.opb}, m);
            acc = 0;
            case (b.cmd)
                gpma_pkg::CMD_ADD: acc = a ^ bb;
                gpma_pkg::CMD_MUL: acc = clmul_mod(a, bb, m);
                gpma_pkg::CMD_DIV:
                    if (invert_mod(bb, m, t))
                        acc = clmul_mod(a, t, m);
                    else
                        ans.st = gpma_pkg::ST_NOINV;
                gpma_pkg::CMD_REC:
                    if (invert_mod(a, m, t))
                        acc = t;
                    else
                        ans.st = gpma_pkg::ST_NOINV;
                gpma_pkg::CMD_POW:
                begin
                    base = a;
                    mag = b.expo;
                    ok = 1'b1;
                    if (b.expo == 0)
                    begin
                        if (a == 0)
                            ans.st = gpma_pkg::ST_ZPOW;
                        else
                            acc = 1;
                        ok = 1'b0;
                    end
                    else if (b.expo[31])
                    begin
                        if (a == 0)
                        begin
                            ans.st = gpma_pkg::ST_NOINV;
                            ok = 1'b0;
                        end
                        else if (b.expo == 32'h8000_0000)
                        begin
                            ans.st = gpma_pkg::ST_MINEXP;
                            ok = 1'b0;
                        end
                        else if (!invert_mod(a, m, base))
                        begin
                            ans.st = gpma_pkg::ST_NOINV;
                            ok = 1'b0;
                        end
                        else
                            mag = ~b.expo + 1;
                    end
                    if (ok)
                    begin
                        acc = 1;
                        while (mag != 0)
                        begin
                            if (mag[0])
                                acc = clmul_mod(acc, base, m);
                            mag >>= 1;
                            base = clmul_mod(base, base, m);
                        end
                    end
                end
                default: acc = 0;
            endcase
            if (ans.st == gpma_pkg::ST_OK)
                ans.poly = acc[30:0];
        end
        return ans;
    endfunction

    // driver: offers the head of the pending queue; the monitor retires it on acceptance
    always @(negedge clk)
    begin
        beat_t nb;
        if (rst_n)
        begin
            if (pending_q.size() > 0 && !cfg_we &&
                $urandom_range(99) >= send_idle_pct)
            begin
                nb = pending_q[0];
                push <= 1'b1;
                command <= nb.cmd;
                operand_a <= nb.opa;
                operand_b <= nb.opb;
                exponent <= nb.expo;
            end
            else
                push <= 1'b0;
        end
    end

    // receiver
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (hold_cycles > 0)
            begin
                hold_cycles <= hold_cycles - 1;
                pop <= 1'b0;
            end
            else
                pop <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // monitor
    always @(posedge clk)
    begin
        answer_t want;
        beat_t   got;
        if (rst_n)
        begin
            if ((push && !full) || (pop && !empty))
                idle_count <= 0;
            else
                idle_count <= idle_count + 1;
            if (push && !full)
            begin
                got = pending_q.pop_front();
                answer_q.push_back(predict_residue(got, modulus));
                beats_sent <= beats_sent + 1;
            end
            if (cfg_we)
                modulus = cfg_wdata;
            if (pop && !empty)
            begin
                results_seen <= results_seen + 1;
                if (answer_q.size() == 0)
                begin
                    mismatches <= mismatches + 1;
                    if (mismatches < 10)
                        $display("unexpected beat: poly %h status %0d", result_poly, status);
                end
                else
                begin
                    want = answer_q.pop_front();
                    if (want.poly !== result_poly || want.st !== status)
                    begin
                        mismatches <= mismatches + 1;
                        if (mismatches < 10)
                            $display("mismatch: exp poly %h st %0d, got poly %h st %0d",
                                     want.poly, want.st, result_poly, status);
                    end
                end
            end
            if (idle_count >= MAX_IDLE)
            begin
                $display("watchdog expired, %0d results still due", answer_q.size());
                $display("FAIL gf2_poly_mod_alu_core");
                $finish;
            end
        end
    end

    function automatic logic [31:0] rand_word();
        case ($urandom_range(5))
            0: return 32'd0;
            1: return 32'hFFFF_FFFF;
            2: return $urandom_range(255);
            3: return 32'd1 << $urandom_range(31);
            default: return $urandom;
        endcase
    endfunction

    task automatic add_beat(logic [2:0] c, logic [31:0] a, logic [31:0] b, logic [31:0] e);
        beat_t nb;
        nb.cmd = c; nb.opa = a; nb.opb = b; nb.expo = e;
        pending_q.push_back(nb);
    endtask

    task automatic drain_all();
        while (pending_q.size() > 0 || answer_q.size() > 0 || in_flight)
        begin
            @(posedge clk);
            in_flight = 1'b0;
        end
        repeat (2200) @(posedge clk);
    endtask

    task automatic set_modulus(logic [31:0] v);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic random_phase(int n);
        logic [31:0] e;
        for (int i = 0; i < n; i++)
        begin
            case ($urandom_range(3))
                0: e = $urandom;
                1: e = $urandom_range(40);
                2: e = -$urandom_range(40);
                default: e = {1'($urandom_range(1)), 31'd0} | 32'($urandom_range(1));
            endcase
            add_beat(3'($urandom_range(7)), rand_word(), rand_word(), e);
        end
    endtask

    initial
    begin
        logic [31:0] moduli[6];
        moduli = '{32'd285, 32'h8000_0000 | 32'h400007, 32'hFFFF_FFFF, 32'd2, 32'd0, 32'd1};
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed beats under the reset modulus
        add_beat(gpma_pkg::CMD_ADD, 32'hFFFF_FFFF, 32'd0, 32'h7FFF_FFFF);
        add_beat(gpma_pkg::CMD_MUL, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0);
        add_beat(gpma_pkg::CMD_DIV, 32'd7, 32'd0, 32'd0);
        add_beat(gpma_pkg::CMD_DIV, 32'd3, 32'd285, 32'd0);
        add_beat(gpma_pkg::CMD_DIV, 32'h53, 32'hCA, 32'd0);
        add_beat(gpma_pkg::CMD_REC, 32'd0, 32'd9, 32'd0);
        add_beat(gpma_pkg::CMD_REC, 32'h53, 32'd0, 32'd0);
        add_beat(gpma_pkg::CMD_POW, 32'd0, 32'd0, 32'd0);
        add_beat(gpma_pkg::CMD_POW, 32'd5, 32'd0, 32'd0);
        add_beat(gpma_pkg::CMD_POW, 32'd0, 32'd0, 32'hFFFF_FFFF);
        add_beat(gpma_pkg::CMD_POW, 32'd0, 32'd0, 32'h8000_0000);
        add_beat(gpma_pkg::CMD_POW, 32'd2, 32'd0, 32'h8000_0000);
        add_beat(gpma_pkg::CMD_POW, 32'd2, 32'd0, 32'hFFFF_FFFD);
        add_beat(gpma_pkg::CMD_POW, 32'd3, 32'd0, 32'h7FFF_FFFF);
        add_beat(3'd5, 32'd1, 32'd1, 32'd1);
        add_beat(3'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        drain_all();

        // non-invertible and invertible cases under a reducible modulus (x^2+1)
        set_modulus(32'd5);
        add_beat(gpma_pkg::CMD_REC, 32'd3, 32'd0, 32'd0);
        add_beat(gpma_pkg::CMD_DIV, 32'd2, 32'd3, 32'd0);
        add_beat(gpma_pkg::CMD_POW, 32'd3, 32'd0, 32'hFFFF_FFFE);
        add_beat(gpma_pkg::CMD_POW, 32'd2, 32'd0, 32'hFFFF_FFFE);
        drain_all();

        for (int ph = 0; ph < 6; ph++)
        begin
            if (ph == 2)
            begin
                send_idle_pct = 62;
                recv_idle_pct = 13;
            end
            if (ph == 4)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            set_modulus(ph == 1 ? 32'h8000_0000 | $urandom : moduli[ph]);
            if (ph == 4)
                hold_cycles = 9000;
            random_phase(ph == 3 || ph == 5 ? 20 : 55);
            drain_all();
        end

        $display("covered %0d beats over 8 modulus settings incl. degenerate and full-width",
                 beats_sent);
        $display("%0d results checked, %0d mismatches", results_seen, mismatches);
        if (mismatches == 0 && answer_q.size() == 0)
            $display("PASS gf2_poly_mod_alu_core");
        else
            $display("FAIL gf2_poly_mod_alu_core");
        $finish;
    end
endmodule
